// ===== design/assert_macros.svh =====
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// ===== design/sstk_pkg.sv =====
package sstk_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int SCORE_W = 32;
    localparam int DOC_W   = 24;
    localparam int WANT_W  = 7;
    localparam int RANK_W  = 6;
    localparam int CNT_W   = 7;
    localparam int ENTRY_W = SCORE_W + DOC_W;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [1:0] ST_STORED  = 2'd0;
    localparam logic [1:0] ST_EVICTED = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

    typedef struct packed {
        logic                      mode;
        logic signed [SCORE_W-1:0] score;
        logic [DOC_W-1:0]          doc_id;
        logic [WANT_W-1:0]         want_count;
    } t_in_item;

    typedef struct packed {
        logic                      kind;
        logic [1:0]                status;
        logic [DOC_W-1:0]          out_doc;
        logic signed [SCORE_W-1:0] out_score;
        logic [RANK_W-1:0]         rank;
        logic                      last;
        logic [CNT_W-1:0]          stored_count;
    } t_out_item;

    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic [DOC_W-1:0]          doc_id;
    } t_entry;

endpackage

// ===== design/sstk_ram.sv =====
module sstk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/sorted_score_topk_table_top.sv =====
// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------
// in       | input     | i_in_valid / o_in_ready   | i_in_item  (t_in_item)
// out      | output    | o_out_valid / i_out_ready | o_out_item (t_out_item)
//
// Insert: a full table first checks the new score against its lowest entry and drops
// it if below; otherwise entries shift down bottom up to open the new slot, and an
// empty table is written straight. A read of n entries returns one entry per result.
// The next item is taken the cycle after the last result loads. Reset (synchronous,
// active low) empties the table; the RAM is not cleared, only slots below the count
// are read. Output stalls freeze the result register and the read or acknowledgement.
module sorted_score_topk_table_top #(
    parameter int CAPACITY = sstk_pkg::CAPACITY_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  sstk_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sstk_pkg::t_out_item o_out_item
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;  // full table: compare against lowest
    localparam logic [2:0] S_WALK = 3'd2;  // shift entries down, bottom up
    localparam logic [2:0] S_PUT  = 3'd3;  // new entry goes to the top slot
    localparam logic [2:0] S_ACK  = 3'd4;  // hand out the insert acknowledgement
    localparam logic [2:0] S_RD   = 3'd5;  // stream entries out

    logic [2:0]                         r_state, n_state;
    logic [CW-1:0]                      r_count, n_count;
    logic [CW-1:0]                      r_n, n_n;
    logic [AW-1:0]                      r_idx, n_idx;
    logic [1:0]                         r_status, n_status;
    logic signed [sstk_pkg::SCORE_W-1:0] r_score, n_score;
    logic [sstk_pkg::DOC_W-1:0]         r_id, n_id;
    logic                               r_out_valid, n_out_valid;
    sstk_pkg::t_out_item                r_out, n_out;

    logic                               ram_wr_en;
    logic [AW-1:0]                      ram_wr_addr;
    sstk_pkg::t_entry                   ram_wr_data;
    logic                               ram_rd_en;
    logic [AW-1:0]                      ram_rd_addr;
    logic [sstk_pkg::ENTRY_W-1:0]       ram_rd_raw;
    sstk_pkg::t_entry                   rd_entry;

    logic                               in_fire;
    logic                               out_free;
    logic [sstk_pkg::CNT_W-1:0]         cnt_ext;
    logic [sstk_pkg::CNT_W-1:0]         take_n;
    logic                               rd_last;

    sstk_ram #(
        .WIDTH (sstk_pkg::ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_raw)
    );

    assign rd_entry    = sstk_pkg::t_entry'(ram_rd_raw);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // read length saturates at the current count
    assign cnt_ext = sstk_pkg::CNT_W'(r_count);
    assign take_n  = (i_in_item.want_count < cnt_ext) ? i_in_item.want_count : cnt_ext;
    assign rd_last = ((CW'(r_idx) + CW'(1)) == r_n);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_n         = r_n;
        n_idx       = r_idx;
        n_status    = r_status;
        n_score     = r_score;
        n_id        = r_id;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        ram_wr_en          = 1'b0;
        ram_wr_addr        = '0;
        ram_wr_data.score  = r_score;
        ram_wr_data.doc_id = r_id;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in_item.mode == sstk_pkg::MODE_INSERT) begin
                        n_score  = i_in_item.score;
                        n_id     = i_in_item.doc_id;
                        n_status = sstk_pkg::ST_STORED;
                        if (r_count == '0) begin
                            // empty table: straight into the top slot
                            ram_wr_en          = 1'b1;
                            ram_wr_addr        = '0;
                            ram_wr_data.score  = i_in_item.score;
                            ram_wr_data.doc_id = i_in_item.doc_id;
                            n_count            = r_count + CW'(1);
                            n_state            = S_ACK;
                        end else if (r_count == CW'(CAPACITY)) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(CAPACITY - 1);
                            n_state     = S_CHK;
                        end else begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = AW'(r_count - CW'(1));
                            n_idx       = AW'(r_count - CW'(1));
                            n_state     = S_WALK;
                        end
                    end else if (take_n != '0) begin
                        n_n         = CW'(take_n);
                        n_idx       = '0;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = '0;
                        n_state     = S_RD;
                    end
                end
            end

            S_CHK: begin
                if (r_score < rd_entry.score) begin
                    n_status = sstk_pkg::ST_DROPPED;
                    n_state  = S_ACK;
                end else begin
                    // lowest slot gets overwritten by the walk
                    n_status    = sstk_pkg::ST_EVICTED;
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = AW'(CAPACITY - 2);
                    n_idx       = AW'(CAPACITY - 2);
                    n_state     = S_WALK;
                end
            end

            S_WALK: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_idx + AW'(1);
                if (rd_entry.score > r_score) begin
                    n_count = (r_status == sstk_pkg::ST_EVICTED) ? r_count
                                                                  : r_count + CW'(1);
                    n_state = S_ACK;
                end else begin
                    ram_wr_data = rd_entry;
                    if (r_idx == '0) begin
                        n_state = S_PUT;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_idx - AW'(1);
                        n_idx       = r_idx - AW'(1);
                    end
                end
            end

            S_PUT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                n_count     = (r_status == sstk_pkg::ST_EVICTED) ? r_count
                                                                  : r_count + CW'(1);
                n_state     = S_ACK;
            end

            S_ACK: begin
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = sstk_pkg::KIND_ACK;
                    n_out.status       = r_status;
                    n_out.out_doc      = '0;
                    n_out.out_score    = '0;
                    n_out.rank         = '0;
                    n_out.last         = 1'b1;
                    n_out.stored_count = sstk_pkg::CNT_W'(r_count);
                    n_state            = S_IDLE;
                end
            end

            S_RD: begin
                // RAM output holds entry r_idx while the output side stalls
                if (out_free) begin
                    n_out_valid        = 1'b1;
                    n_out.kind         = sstk_pkg::KIND_READ;
                    n_out.status       = sstk_pkg::ST_STORED;
                    n_out.out_doc      = rd_entry.doc_id;
                    n_out.out_score    = rd_entry.score;
                    n_out.rank         = sstk_pkg::RANK_W'(r_idx);
                    n_out.last         = rd_last;
                    n_out.stored_count = sstk_pkg::CNT_W'(r_count);
                    if (rd_last) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_idx + AW'(1);
                        n_idx       = r_idx + AW'(1);
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n      <= n_n;
        r_idx    <= n_idx;
        r_status <= n_status;
        r_score  <= n_score;
        r_id     <= n_id;
        r_out    <= n_out;
    end

endmodule

// ===== design/sstk_check.sv =====
`include "assert_macros.svh"

module sstk_check #(
    parameter int CAPACITY = sstk_pkg::CAPACITY_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input sstk_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input sstk_pkg::t_out_item o_out_item
);

    logic out_fire;
    logic out_stall;
    logic in_wait;
    logic ack_out;
    logic ack_ok;
    logic rd_more;

    assign out_fire  = o_out_valid && i_out_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign in_wait   = i_in_valid && !o_in_ready;
    assign ack_out   = o_out_valid && (o_out_item.kind == sstk_pkg::KIND_ACK);
    assign ack_ok    = o_out_item.last && (o_out_item.rank == '0)
                       && (o_out_item.out_doc == '0) && (o_out_item.out_score == '0);
    assign rd_more   = out_fire && (o_out_item.kind == sstk_pkg::KIND_READ)
                       && !o_out_item.last;

    // waiting input item holds
    `ASSERT_CLK(a_in_hold, i_clk, i_rst_n, in_wait |=> (i_in_valid && $stable(i_in_item)), "waiting input item changed")

    // stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, out_stall |=> (o_out_valid && $stable(o_out_item)), "stalled result changed")

    // acknowledgement is a single, final item with empty entry fields
    `ASSERT_CLK(a_ack_shape, i_clk, i_rst_n, ack_out |-> ack_ok, "malformed insert acknowledgement")

    // count never exceeds the table size
    `ASSERT_NEVER(a_count_range, i_clk, i_rst_n, o_out_valid && (o_out_item.stored_count > sstk_pkg::CNT_W'(CAPACITY)), "stored count above capacity")

    // read entries come out in rank order with no gaps
    `ASSERT_CLK(a_rank_seq, i_clk, i_rst_n, rd_more |=> (!o_out_valid || (o_out_item.kind == sstk_pkg::KIND_READ && o_out_item.rank == $past(o_out_item.rank) + 1'b1)), "read rank sequence broken")

endmodule

bind sorted_score_topk_table_top sstk_check #(
    .CAPACITY (CAPACITY)
) u_sstk_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== tb/sv/sorted_score_topk_table_top_tb.sv =====
module sorted_score_topk_table_top_tb;

    import sstk_pkg::*;

    // Table depth under test: the full default, so eviction and drop are reached.
    localparam int unsigned TABLE_DEPTH    = CAPACITY_DEF;
    localparam int unsigned RANDOM_ITEMS   = 366;
    // Idle cycles tolerated with no item moving on either channel. The worst
    // honest case is the long output hold-off plus one full insert walk.
    localparam int unsigned WATCHDOG_LIMIT = 2000;
    // Quiet cycles after the last expected result, to catch stray results.
    localparam int unsigned DRAIN_CYCLES   = 150;
    // Output hold-off that forces the block to stall its input.
    localparam int unsigned HOLD_OFF_LEN   = 400;
    localparam int unsigned HOLD_OFF_AT    = 120;
    // Item window in which neither side idles.
    localparam int unsigned CALM_FROM      = 200;
    localparam int unsigned CALM_TO        = 270;

    // Mirror of the table plus the queue of results still owed by the block.
    class sorted_table_sb;
        int unsigned capacity;
        int unsigned errors;
        int unsigned checked;
        t_entry      ranked_entries[$];
        t_out_item   pending_results[$];

        function new(int unsigned cap);
            capacity = cap;
            errors   = 0;
            checked  = 0;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[tb] result %0d: %s", checked, msg);
        endtask

        function void push_result(logic kind, logic [1:0] st, t_entry e,
                                  logic [RANK_W-1:0] rnk, logic lst);
            t_out_item r;
            r.kind         = kind;
            r.status       = st;
            r.out_doc      = e.doc_id;
            r.out_score    = e.score;
            r.rank         = rnk;
            r.last         = lst;
            r.stored_count = CNT_W'(ranked_entries.size());
            pending_results.push_back(r);
        endfunction

        // Apply one accepted item to the mirror and queue what it must produce.
        function void note_item(t_in_item it);
            logic signed [SCORE_W-1:0] s;
            logic [1:0]                st;
            int unsigned               pos;
            int unsigned               n;
            t_entry                    e;
            s  = it.score;
            st = ST_STORED;
            if (it.mode == MODE_INSERT) begin
                if (ranked_entries.size() >= capacity) begin
                    // full: below the lowest is dropped, equal or above evicts it
                    if (s < ranked_entries[capacity-1].score) begin
                        push_result(KIND_ACK, ST_DROPPED, '0, '0, 1'b1);
                        return;
                    end
                    st = ST_EVICTED;
                    void'(ranked_entries.pop_back());
                end
                pos = 0;
                while (pos < ranked_entries.size() && ranked_entries[pos].score > s) begin
                    pos++;
                end
                e.score  = s;
                e.doc_id = it.doc_id;
                ranked_entries.insert(pos, e);
                push_result(KIND_ACK, st, '0, '0, 1'b1);
            end else begin
                n = it.want_count;
                if (n > ranked_entries.size()) n = ranked_entries.size();
                for (int unsigned i = 0; i < n; i++) begin
                    push_result(KIND_READ, ST_STORED, ranked_entries[i], RANK_W'(i),
                                i + 1 == n);
                end
            end
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %0h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind)
                    report_mismatch($sformatf("kind %0h, want %0h", got.kind, want.kind));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0h, want %0h",
                                              got.status, want.status));
                if (got.out_doc !== want.out_doc)
                    report_mismatch($sformatf("out_doc %0h, want %0h",
                                              got.out_doc, want.out_doc));
                if (got.out_score !== want.out_score)
                    report_mismatch($sformatf("out_score %0h, want %0h",
                                              got.out_score, want.out_score));
                if (got.rank !== want.rank)
                    report_mismatch($sformatf("rank %0d, want %0d", got.rank, want.rank));
                if (got.last !== want.last)
                    report_mismatch($sformatf("last %0h, want %0h", got.last, want.last));
                if (got.stored_count !== want.stored_count)
                    report_mismatch($sformatf("stored_count %0d, want %0d",
                                              got.stored_count, want.stored_count));
            end
            checked++;
        endtask
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    sorted_table_sb sb = new(TABLE_DEPTH);

    int unsigned items_sent   = 0;
    int unsigned stall_cycles = 0;
    bit          calm         = 1'b0;

    sorted_score_topk_table_top #(
        .CAPACITY (TABLE_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item insert_item(logic signed [SCORE_W-1:0] sc,
                                             logic [DOC_W-1:0] doc);
        t_in_item it;
        it            = '0;
        it.mode       = MODE_INSERT;
        it.score      = sc;
        it.doc_id     = doc;
        // ignored on an insert, but toggled anyway
        it.want_count = WANT_W'($urandom_range(64));
        return it;
    endfunction

    function automatic t_in_item read_item(int unsigned want);
        t_in_item it;
        it            = '0;
        it.mode       = MODE_READ;
        it.score      = $urandom;
        it.doc_id     = DOC_W'($urandom);
        it.want_count = WANT_W'(want);
        return it;
    endfunction

    // Offer one item and hold it until accepted. Called at a rising edge; the
    // item counts as taken when valid and ready were both high at the edge.
    // Only one nonblocking write of valid lands in any time step.
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        gap = 0;
        while (!calm && $urandom_range(99) < 37) gap++;
        if (!calm && $urandom_range(19) == 0) gap += $urandom_range(30);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        items_sent++;
        calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
    endtask

    // Output side: random stalls, one long hold-off once the run is under way
    // (the sender keeps offering, so the block backs up), and no stalls at all
    // through the calm window.
    initial begin : out_side
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (!held && items_sent >= HOLD_OFF_AT) begin
                held        = 1'b1;
                hold_left   = HOLD_OFF_LEN - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 37);
            end
        end
    end

    // Result checker and watchdog. Values read right after the edge are the
    // ones the block saw at that edge, since everything is driven by NBA.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                sb.check_result(o_out_item);
            end
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= WATCHDOG_LIMIT) begin
                    $display("[tb] no item moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("[sorted_score_topk_table_top] ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin : in_side
        t_in_item                  it;
        logic signed [SCORE_W-1:0] sc;
        logic signed [SCORE_W-1:0] lowest;
        int unsigned               pick;
        int unsigned               sel;
        int unsigned               want;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: empty-table reads, zero-count read, score and id
        // extremes, ties (newest first), saturating reads.
        send_item(read_item(5));
        send_item(read_item(0));
        send_item(insert_item(32'sd0, 24'h000000));
        send_item(insert_item(32'sh7fffffff, 24'hffffff));
        send_item(insert_item(32'sh80000000, 24'h123456));
        send_item(insert_item(32'sd0, 24'h000001));
        send_item(insert_item(32'sd0, 24'h000002));
        send_item(read_item(0));
        send_item(read_item(64));
        send_item(read_item(1));
        send_item(read_item(3));
        send_item(insert_item(32'shffffffff, 24'haaaaaa));
        send_item(insert_item(32'sh00010000, 24'h555555));
        send_item(insert_item(32'sh80000000, 24'h000003));
        send_item(insert_item(32'sh7fffffff, 24'h000004));
        send_item(read_item(64));

        // Random part. Inserts dominate so the table fills early; after that
        // scores equal to the lowest (evicts it) and just below it (dropped)
        // keep hitting the full-table cases.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            pick   = $urandom_range(99);
            lowest = sb.ranked_entries.size() > 0 ? sb.ranked_entries[$].score : '0;
            if (pick < 30) begin
                sel = $urandom_range(9);
                if (sel == 0)     want = 0;
                else if (sel == 1) want = 64;
                else if (sel < 6)  want = $urandom_range(8);
                else               want = $urandom_range(64);
                it = read_item(want);
            end else begin
                sel = $urandom_range(99);
                if (sel < 10 && sb.ranked_entries.size() > 0) begin
                    sc = lowest;
                end else if (sel < 20 && sb.ranked_entries.size() > 0
                             && lowest != 32'sh80000000) begin
                    sc = lowest - 1;
                end else if (sel < 25) begin
                    sc = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
                end else if (sel < 55) begin
                    // small pool of whole numbers in Q16.16: plenty of ties
                    sc = (int'($urandom_range(8)) - 4) * 65536;
                end else begin
                    sc = $urandom;
                end
                it = insert_item(sc, DOC_W'($urandom));
            end
            send_item(it);
        end
        i_in_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("[sorted_score_topk_table_top] OK");
        end else begin
            $display("[sorted_score_topk_table_top] ERROR");
        end
        $finish;
    end

endmodule
